/* sv/htwd_pkg.sv */
`timescale 1ns / 1ps

package htwd_pkg;

	// Size of the node table.
	localparam int NODE_COUNT = 512;
	localparam int IDX_W      = $clog2(NODE_COUNT);

	// Fixed field widths of the item ports.
	localparam int CHILD_W = 9;
	localparam int SYM_W   = 8;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 4;

	// Command codes.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// One node table entry.
	typedef struct packed {
		logic [CHILD_W-1:0] zero_child;
		logic [CHILD_W-1:0] one_child;
		logic               leaf;
		logic [SYM_W-1:0]   sym;
	} node_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	// True when a child index does not address a table entry.
	function automatic logic child_oor(input logic [CHILD_W-1:0] child);
		return 32'(child) >= NODE_COUNT;
	endfunction

endpackage

/* sv/huffman_tree_walk_decoder.sv */
`timescale 1ns / 1ps

// Bit-serial Huffman decoder that walks a code tree held in a node table.
// Input channel (in_valid / in_ready): one word per item. With cmd = load the
// word writes one table node (children, leaf mark, symbol); it leaves the block
// idle and produces nothing. With cmd = decode the word carries one
// compressed byte, used least significant bit first, valid_bits of it.
// Output channel (out_valid / out_ready): one word per decoded symbol;
// last_of_run marks the last symbol a byte produced.
// A decode byte occupies the block, and no new word is taken, until all its
// used bits are walked and the byte is flushed; every bit needs one table read
// whose data selects the address of the next read. A decoded symbol waits in a
// holding register until the byte yields its next symbol or ends, and then
// moves to the output register; the last symbol of a byte leaves through the
// flush state, marked with last_of_run.
// Reset clears the walk to the root and empties the output register; the
// node table is not cleared and must be loaded before decoding.
// When the receiver stalls, one symbol waits in the output register and one
// more is held back; the walk then pauses on the next leaf until room frees.
module huffman_tree_walk_decoder
	import htwd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [CHILD_W-1:0] node_index,
	input  logic [CHILD_W-1:0] zero_child,
	input  logic [CHILD_W-1:0] one_child,
	input  logic               node_is_leaf,
	input  logic [SYM_W-1:0]   node_symbol,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic [CNT_W-1:0]   valid_bits,
	input  logic               end_of_stream,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SYM_W-1:0]   symbol,
	output logic               last_of_run
);

	// Node table: one write port for loads, one read port for the walk.
	node_t mem [NODE_COUNT];

	state_t state_q, state_d;

	// Walk position and a copy of its node entry, plus a copy of the root.
	logic [IDX_W-1:0] walk_q, walk_d;
	node_t            cur_q, cur_d;
	node_t            root_q, root_d;

	// Byte under decode.
	logic [BYTE_W-1:0] byte_q, byte_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  bit_q, bit_d;
	logic              eos_q, eos_d;

	// Read in flight: the addressed child and whether it is out of range.
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	node_t            rd_q;
	logic [IDX_W-1:0] nxt_q, nxt_d;
	logic             oor_q, oor_d;

	// Write port.
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	node_t            wr_data;

	// Symbol held back until we know whether it is the last of its byte.
	logic             held_valid_q, held_valid_d;
	logic [SYM_W-1:0] held_sym_q, held_sym_d;

	// Output register.
	logic             out_valid_q, out_valid_d;
	logic [SYM_W-1:0] out_sym_q, out_sym_d;
	logic             out_last_q, out_last_d;

	// Scratch for the walk step.
	logic               out_free;
	logic               emit;
	node_t              step_cur;
	logic [CNT_W-1:0]   bit_nx;
	logic [CHILD_W-1:0] child_sel;
	logic [CNT_W-1:0]   cnt_clamp;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign symbol      = out_sym_q;
	assign last_of_run = out_last_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			walk_q       <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			walk_q       <= walk_d;
			held_valid_q <= held_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q      <= cur_d;
		root_q     <= root_d;
		byte_q     <= byte_d;
		count_q    <= count_d;
		bit_q      <= bit_d;
		eos_q      <= eos_d;
		nxt_q      <= nxt_d;
		oor_q      <= oor_d;
		held_sym_q <= held_sym_d;
		out_sym_q  <= out_sym_d;
		out_last_q <= out_last_d;
	end

	always_comb begin
		state_d      = state_q;
		walk_d       = walk_q;
		cur_d        = cur_q;
		root_d       = root_q;
		byte_d       = byte_q;
		count_d      = count_q;
		bit_d        = bit_q;
		eos_d        = eos_q;
		nxt_d        = nxt_q;
		oor_d        = oor_q;
		held_valid_d = held_valid_q;
		held_sym_d   = held_sym_q;
		out_sym_d    = out_sym_q;
		out_last_d   = out_last_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = IDX_W'(node_index);
		wr_data      = '{zero_child: zero_child, one_child: one_child,
		                 leaf: node_is_leaf, sym: node_symbol};
		emit         = 1'b0;
		step_cur     = cur_q;
		bit_nx       = bit_q + CNT_W'(1);
		child_sel    = '0;
		cnt_clamp    = (valid_bits > CNT_W'(BYTE_W)) ? CNT_W'(BYTE_W) : valid_bits;

		out_free    = !out_valid_q || out_ready;
		out_valid_d = out_valid_q && !out_ready;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_LOAD) begin
						if (!child_oor(node_index)) begin
							wr_en = 1'b1;
							if (IDX_W'(node_index) == '0) begin
								root_d = wr_data;
							end
							// Keep the cached walk entry in step with the table.
							if (IDX_W'(node_index) == walk_q) begin
								cur_d = wr_data;
							end
						end
					end else begin
						byte_d  = data_byte;
						count_d = cnt_clamp;
						eos_d   = end_of_stream;
						bit_d   = '0;
						if (cnt_clamp == '0) begin
							state_d = ST_FLUSH;
						end else begin
							child_sel = data_byte[0] ? cur_q.one_child : cur_q.zero_child;
							rd_en     = 1'b1;
							rd_addr   = IDX_W'(child_sel);
							nxt_d     = IDX_W'(child_sel);
							oor_d     = child_oor(child_sel);
							state_d   = ST_WALK;
						end
					end
				end
			end

			ST_WALK: begin
				emit = !oor_q && rd_q.leaf;
				// A new symbol pushes the held one out; wait if there is no room.
				if (!(emit && held_valid_q && !out_free)) begin
					if (emit) begin
						if (held_valid_q) begin
							out_valid_d = 1'b1;
							out_sym_d   = held_sym_q;
							out_last_d  = 1'b0;
						end
						held_valid_d = 1'b1;
						held_sym_d   = rd_q.sym;
						walk_d       = '0;
						step_cur     = root_q;
					end else if (oor_q) begin
						walk_d   = '0;
						step_cur = root_q;
					end else begin
						walk_d   = nxt_q;
						step_cur = rd_q;
					end
					cur_d = step_cur;
					bit_d = bit_nx;
					if (bit_nx == count_q) begin
						state_d = ST_FLUSH;
					end else begin
						child_sel = byte_q[bit_nx[$clog2(BYTE_W)-1:0]] ?
						            step_cur.one_child : step_cur.zero_child;
						rd_en   = 1'b1;
						rd_addr = IDX_W'(child_sel);
						nxt_d   = IDX_W'(child_sel);
						oor_d   = child_oor(child_sel);
					end
				end
			end

			ST_FLUSH: begin
				if (!held_valid_q || out_free) begin
					if (held_valid_q) begin
						out_valid_d  = 1'b1;
						out_sym_d    = held_sym_q;
						out_last_d   = 1'b1;
						held_valid_d = 1'b0;
					end
					if (eos_q) begin
						walk_d = '0;
						cur_d  = root_q;
					end
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// No symbol is left held back once the block is ready for a new word.
	a_idle_nothing_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !held_valid_q)
		else $error("held symbol left over in idle");

	// A table read is always followed by the walk state, which consumes it.
	a_read_feeds_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> state_q == ST_WALK)
		else $error("table read issued outside the walk");

	// End of stream returns the walk to the root when the byte completes.
	a_eos_to_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && state_d == ST_IDLE && eos_q) |=> walk_q == '0)
		else $error("walk not at root after end of stream");

	// Loads never write the table while a decode is under way.
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_IDLE)
		else $error("table written during decode");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

// Testbench for the tree-walk decoder. Trees are loaded node by node, then
// bytes are pushed through and each decoded symbol word is compared with what
// an in-bench walk of the same table predicts.
module tb;
	import htwd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [SYM_W-1:0] sym;
		logic             last;
	} sym_word_t;

	typedef enum logic [1:0] {
		RX_FULL,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic               cmd           = CMD_LOAD;
	logic [CHILD_W-1:0] node_index    = '0;
	logic [CHILD_W-1:0] zero_child    = '0;
	logic [CHILD_W-1:0] one_child     = '0;
	logic               node_is_leaf  = 1'b0;
	logic [SYM_W-1:0]   node_symbol   = '0;
	logic [BYTE_W-1:0]  data_byte     = '0;
	logic [CNT_W-1:0]   valid_bits    = '0;
	logic               end_of_stream = 1'b0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic [SYM_W-1:0]   symbol;
	logic               last_of_run;

	huffman_tree_walk_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.node_index   (node_index),
		.zero_child   (zero_child),
		.one_child    (one_child),
		.node_is_leaf (node_is_leaf),
		.node_symbol  (node_symbol),
		.data_byte    (data_byte),
		.valid_bits   (valid_bits),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.symbol       (symbol),
		.last_of_run  (last_of_run)
	);

	// Predicted copy of the block's state. The written flags keep every
	// generated child pointing at an entry that has been loaded, so the walk
	// never reads an undefined node.
	node_t            tree_mem [NODE_COUNT];
	bit               written  [NODE_COUNT];
	int               written_list[$];
	logic [IDX_W-1:0] walk_node = '0;

	sym_word_t expected_symbols[$];
	sym_word_t head;
	int        mismatches  = 0;
	int        cycle_count = 0;

	// Sender burst control and receiver stall control.
	bit        tx_idle       = 1'b0;
	int        burst_left    = 0;
	rx_mode_t  rx_mode       = RX_FULL;
	int        rx_pct        = 100;
	logic [15:0] rx_pattern  = 16'hFFFF;
	logic [3:0]  rx_phase    = '0;
	bit        stall_request = 1'b0;
	int        hold_left     = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("huffman_tree_walk_decoder test failed");
			$finish;
		end
	end

	// The receiver changes out_ready on the falling edge. A long hold-off is
	// counted down here so the sender keeps offering words meanwhile.
	always @(negedge clk) begin
		if (stall_request) begin
			hold_left = HOLD_CYCLES;
			stall_request = 1'b0;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			case (rx_mode)
				RX_FULL: begin
					out_ready = 1'b1;
				end
				RX_RANDOM: begin
					out_ready = ($urandom_range(0, 99) < rx_pct);
				end
				default: begin
					out_ready = rx_pattern[rx_phase];
					rx_phase = rx_phase + 1'b1;
				end
			endcase
		end
	end

	// Every accepted symbol word is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_symbols.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual symbol %02h last %b",
					$time, symbol, last_of_run);
				mismatches++;
			end else begin
				head = expected_symbols.pop_front();
				if (symbol !== head.sym) begin
					$display("%0t: symbol expected %02h actual %02h",
						$time, head.sym, symbol);
					mismatches++;
				end
				if (last_of_run !== head.last) begin
					$display("%0t: last_of_run expected %b actual %b",
						$time, head.last, last_of_run);
					mismatches++;
				end
			end
		end
	end

	function automatic void store_node(input logic [CHILD_W-1:0] idx,
		input logic [CHILD_W-1:0] zc, input logic [CHILD_W-1:0] oc,
		input logic lf, input logic [SYM_W-1:0] sy);
		// With 512 entries every 9-bit index is in range, so no load is dropped.
		tree_mem[idx] = '{zero_child: zc, one_child: oc, leaf: lf, sym: sy};
		if (!written[idx]) begin
			written[idx] = 1'b1;
			written_list.push_back(int'(idx));
		end
	endfunction

	// Walks the predicted table over the used bits of one byte. The root is
	// never checked for a leaf mark; only the node reached by a bit is.
	function automatic void walk_tree(input logic [BYTE_W-1:0] db,
		input logic [CNT_W-1:0] vb, input logic eo);
		sym_word_t        run[$];
		int               nbits;
		logic [IDX_W-1:0] nxt;
		nbits = (vb > 8) ? 8 : int'(vb);
		for (int b = 0; b < nbits; b++) begin
			nxt = db[b] ? tree_mem[walk_node].one_child : tree_mem[walk_node].zero_child;
			// Every 9-bit child addresses an entry here, so there is no
			// out-of-range return to the root.
			if (tree_mem[nxt].leaf) begin
				run.push_back('{sym: tree_mem[nxt].sym, last: 1'b0});
				walk_node = '0;
			end else begin
				walk_node = nxt;
			end
		end
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			expected_symbols.push_back(run[i]);
		if (eo)
			walk_node = '0;
	endfunction

	// Offers one word and returns at the rising edge that accepts it.
	task automatic send_word(input logic c, input logic [CHILD_W-1:0] idx,
		input logic [CHILD_W-1:0] zc, input logic [CHILD_W-1:0] oc,
		input logic lf, input logic [SYM_W-1:0] sy,
		input logic [BYTE_W-1:0] db, input logic [CNT_W-1:0] vb, input logic eo);
		int gap;
		if (tx_idle && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		cmd           = c;
		node_index    = idx;
		zero_child    = zc;
		one_child     = oc;
		node_is_leaf  = lf;
		node_symbol   = sy;
		data_byte     = db;
		valid_bits    = vb;
		end_of_stream = eo;
		in_valid      = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (c == CMD_LOAD)
			store_node(idx, zc, oc, lf, sy);
		else
			walk_tree(db, vb, eo);
	endtask

	// The fields that the command does not use carry random values.
	task automatic load_node(input int idx, input int zc, input int oc,
		input logic lf, input logic [SYM_W-1:0] sy);
		send_word(CMD_LOAD, CHILD_W'(idx), CHILD_W'(zc), CHILD_W'(oc), lf, sy,
			BYTE_W'($urandom), CNT_W'($urandom), 1'($urandom));
	endtask

	task automatic decode_byte(input logic [BYTE_W-1:0] db, input int vb,
		input logic eo);
		send_word(CMD_DECODE, CHILD_W'($urandom), CHILD_W'($urandom),
			CHILD_W'($urandom), 1'($urandom), SYM_W'($urandom),
			db, CNT_W'(vb), eo);
	endtask

	task automatic pick_idling();
		tx_idle    = ($urandom_range(0, 3) != 0);
		burst_left = 0;
		rx_mode    = rx_mode_t'($urandom_range(0, 2));
		rx_pct     = $urandom_range(30, 90);
		rx_pattern = 16'($urandom) | 16'h0001;
	endtask

	// Builds a random full binary tree rooted at node 0 and loads it in a
	// shuffled order. A skewed tree always splits the newest leaf, which
	// gives long codes that cross byte boundaries.
	task automatic build_tree(input int leaves, input bit skewed);
		int    open_leaves[$];
		int    tree_nodes[$];
		bit    taken[NODE_COUNT];
		node_t shape[NODE_COUNT];
		int    pick, parent, a, b, j, tmp;
		foreach (taken[i])
			taken[i] = 1'b0;
		taken[0] = 1'b1;
		open_leaves.push_back(0);
		tree_nodes.push_back(0);
		for (int k = 1; k < leaves; k++) begin
			pick = skewed ? open_leaves.size() - 1 : $urandom_range(0, open_leaves.size() - 1);
			parent = open_leaves[pick];
			open_leaves.delete(pick);
			do a = $urandom_range(1, NODE_COUNT - 1); while (taken[a]);
			taken[a] = 1'b1;
			do b = $urandom_range(1, NODE_COUNT - 1); while (taken[b]);
			taken[b] = 1'b1;
			shape[parent] = '{zero_child: CHILD_W'(a), one_child: CHILD_W'(b),
				leaf: 1'b0, sym: SYM_W'($urandom)};
			if ($urandom_range(0, 1)) begin
				open_leaves.push_back(a);
				open_leaves.push_back(b);
			end else begin
				open_leaves.push_back(b);
				open_leaves.push_back(a);
			end
			tree_nodes.push_back(a);
			tree_nodes.push_back(b);
		end
		// Leaf children are stored too; they point inside the same tree.
		foreach (open_leaves[i])
			shape[open_leaves[i]] = '{
				zero_child: CHILD_W'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]),
				one_child:  CHILD_W'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]),
				leaf: 1'b1, sym: SYM_W'($urandom)};
		for (int i = tree_nodes.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = tree_nodes[i];
			tree_nodes[i] = tree_nodes[j];
			tree_nodes[j] = tmp;
		end
		foreach (tree_nodes[i])
			load_node(tree_nodes[i], shape[tree_nodes[i]].zero_child,
				shape[tree_nodes[i]].one_child, shape[tree_nodes[i]].leaf,
				shape[tree_nodes[i]].sym);
	endtask

	// Mostly full bytes with random content; some short or oversized counts,
	// a few end-of-stream marks and occasional reloads of loaded nodes.
	task automatic run_stream(input int count);
		int vb;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 8) begin
				load_node(written_list[$urandom_range(0, written_list.size() - 1)],
					written_list[$urandom_range(0, written_list.size() - 1)],
					written_list[$urandom_range(0, written_list.size() - 1)],
					1'($urandom), SYM_W'($urandom));
			end else begin
				vb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 8;
				decode_byte(BYTE_W'($urandom), vb, $urandom_range(0, 9) == 0);
			end
		end
	endtask

	// Fixed tree: bit 0 gives FF, bits 1,0 give 00, bits 1,1 give 5A.
	task automatic test_directed();
		tx_idle = 1'b0;
		rx_mode = RX_FULL;
		load_node(0, 511, 170, 1'b0, 8'h00);
		load_node(511, 0, 0, 1'b1, 8'hFF);
		load_node(170, 341, 256, 1'b0, 8'h5A);
		load_node(341, 511, 511, 1'b1, 8'h00);
		load_node(256, 170, 0, 1'b1, 8'h5A);
		decode_byte(8'h00, 8, 1'b0);
		decode_byte(8'hFF, 8, 1'b0);
		// A load in the middle of a code leaves the walk where it is.
		decode_byte(8'h01, 1, 1'b0);
		load_node(511, 0, 0, 1'b1, 8'hFF);
		decode_byte(8'h00, 1, 1'b0);
		// End of stream drops a partial code.
		decode_byte(8'h01, 1, 1'b1);
		decode_byte(8'h00, 1, 1'b0);
		// Zero bits decode nothing, but end of stream still resets the walk.
		decode_byte(8'hAB, 0, 1'b0);
		decode_byte(8'h01, 1, 1'b0);
		decode_byte(8'h00, 0, 1'b1);
		decode_byte(8'h00, 1, 1'b0);
		// Counts above eight are clamped to eight.
		decode_byte(8'h00, 15, 1'b0);
		decode_byte(8'h3C, 9, 1'b0);
		// The node under the walk becomes a leaf; the walk moves on from it.
		decode_byte(8'h01, 1, 1'b0);
		load_node(170, 511, 341, 1'b1, 8'h33);
		decode_byte(8'h00, 1, 1'b0);
		decode_byte(8'h03, 2, 1'b0);
		// A leaf mark on the root is never looked at.
		load_node(0, 511, 170, 1'b1, 8'h77);
		decode_byte(8'h00, 2, 1'b1);
	endtask

	task automatic test_random_trees();
		int sizes[5] = '{2, 3, 6, 12, 24};
		foreach (sizes[i]) begin
			pick_idling();
			build_tree(sizes[i], 1'b0);
			run_stream(12);
		end
	endtask

	task automatic test_long_codes();
		pick_idling();
		build_tree($urandom_range(12, 20), 1'b1);
		run_stream(20);
	endtask

	// The receiver holds off for a long stretch while full bytes keep
	// coming, so the output side fills and the input stalls.
	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_mode = RX_FULL;
		build_tree(2, 1'b0);
		stall_request = 1'b1;
		for (int n = 0; n < 10; n++)
			decode_byte(BYTE_W'($urandom), 8, 1'b0);
		pick_idling();
		run_stream(20);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_trees();
		test_long_codes();
		test_backpressure();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_symbols.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_symbols.size() == 0)
			$display("huffman_tree_walk_decoder test passed");
		else
			$display("huffman_tree_walk_decoder test failed");
		$finish;
	end

endmodule
